FILE: rtl/lfbr_pkg.sv
// Shared types and constants for the length framed byte receiver.
// Used by lfbr_out, lfbr_ctrl and the top level; depends on nothing.
package lfbr_pkg;

    localparam int BUF_BYTES_DEF = 64;
    localparam int POS_W         = 6;
    localparam int LEN_W         = 16;
    localparam int KIND_W        = 3;
    localparam int HDR_BYTES     = 3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_BYTE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BADSIZE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOTERM   = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_START_CHAR = 1'b0;
    localparam logic CFG_END_CHAR   = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        payload_byte;
        logic [POS_W-1:0]  msg_length;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_push;

endpackage

FILE: rtl/lfbr_store.sv
// Frame store of the length framed byte receiver: one write port and one
// read port, read data registered. Depends on nothing but its parameters.
module lfbr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lfbr_out.sv
// Output register of the length framed byte receiver: holds one result word
// until the master side takes it. Depends on lfbr_pkg.
module lfbr_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfbr_pkg::t_res_push i_push,
    output logic               o_slot_free,
    output logic               o_valid,
    input  logic               i_ready,
    output lfbr_pkg::t_result  o_res
);
    import lfbr_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_push.valid) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_push.valid) begin
            r_res <= i_push.res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: rtl/lfbr_ctrl.sv
// Frame parser and replay sequencer of the length framed byte receiver.
// Drives the frame store and the output register. Depends on lfbr_pkg.
module lfbr_ctrl #(
    parameter int BUF_BYTES = lfbr_pkg::BUF_BYTES_DEF,
    parameter int AW        = $clog2(BUF_BYTES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output logic [7:0]          o_wdata,
    output logic                o_re,
    output logic [AW-1:0]       o_raddr,
    input  logic [7:0]          i_rdata,
    input  logic                i_slot_free,
    output lfbr_pkg::t_res_push o_push
);
    import lfbr_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LEN    = 2'd1;
    localparam logic [1:0] ST_DATA   = 2'd2;
    localparam logic [1:0] ST_REPLAY = 2'd3;

    localparam logic [POS_W:0] BUF_LIM = (POS_W + 1)'(BUF_BYTES);
    localparam logic [POS_W:0] HDR     = (POS_W + 1)'(HDR_BYTES);

    logic [1:0]       r_state,     n_state;
    logic [POS_W-1:0] r_pos,       n_pos;
    logic [LEN_W-1:0] r_decl,      n_decl;
    logic [POS_W-1:0] r_len,       n_len;
    logic [POS_W-1:0] r_rd_cnt,    n_rd_cnt;
    logic             r_pend,      n_pend;
    logic             r_pend_last, n_pend_last;
    logic [7:0]       r_start_char;
    logic [7:0]       r_end_char;

    logic             acc;
    logic             load;
    logic [POS_W:0]   widx;
    logic [POS_W:0]   ridx;

    assign o_ready = (r_state != ST_REPLAY) && i_slot_free;
    assign acc     = i_valid && o_ready;
    assign load    = r_pend && i_slot_free;
    assign widx    = {1'b0, r_pos} + HDR;
    assign ridx    = {1'b0, r_rd_cnt} + HDR;
    assign o_waddr = widx[AW-1:0];
    assign o_raddr = ridx[AW-1:0];
    assign o_wdata = i_byte;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_decl      = r_decl;
        n_len       = r_len;
        n_rd_cnt    = r_rd_cnt;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        o_we        = 1'b0;
        o_re        = 1'b0;
        o_push      = '0;

        case (r_state)
            ST_IDLE: begin
                if (acc && (i_byte == r_start_char)) begin
                    n_state = ST_LEN;
                    n_pos   = '0;
                    n_decl  = '0;
                end
            end
            ST_LEN: begin
                if (acc) begin
                    if (!r_pos[0]) begin
                        n_decl = {r_decl[LEN_W-1:8], i_byte};
                        n_pos  = POS_W'(1);
                    end else begin
                        n_decl  = {i_byte, r_decl[7:0]};
                        n_state = ST_DATA;
                        n_pos   = '0;
                    end
                end
            end
            ST_DATA: begin
                if (acc) begin
                    if (widx >= BUF_LIM) begin
                        n_state              = ST_IDLE;
                        n_pos                = '0;
                        o_push.valid         = 1'b1;
                        o_push.res.kind      = KIND_OVERFLOW;
                        o_push.res.last      = 1'b1;
                    end else begin
                        o_we = 1'b1;
                        if (i_byte == r_end_char) begin
                            n_state = ST_IDLE;
                            n_pos   = '0;
                            if ({{(LEN_W - POS_W){1'b0}}, r_pos} != r_decl) begin
                                o_push.valid    = 1'b1;
                                o_push.res.kind = KIND_BADSIZE;
                                o_push.res.last = 1'b1;
                            end else if (r_pos == '0) begin
                                o_push.valid    = 1'b1;
                                o_push.res.kind = KIND_EMPTY;
                                o_push.res.last = 1'b1;
                            end else begin
                                n_state  = ST_REPLAY;
                                n_len    = r_pos;
                                n_rd_cnt = '0;
                                n_pend   = 1'b0;
                            end
                        end else if ({{(LEN_W - POS_W){1'b0}}, r_pos} == r_decl) begin
                            n_state         = ST_IDLE;
                            n_pos           = '0;
                            o_push.valid    = 1'b1;
                            o_push.res.kind = KIND_NOTERM;
                            o_push.res.last = 1'b1;
                        end else begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                end
            end
            ST_REPLAY: begin
                if (load) begin
                    o_push.valid            = 1'b1;
                    o_push.res.kind         = KIND_BYTE;
                    o_push.res.payload_byte = i_rdata;
                    o_push.res.msg_length   = r_len;
                    o_push.res.last         = r_pend_last;
                    n_pend                  = 1'b0;
                end
                if (!r_pend || load) begin
                    if (r_rd_cnt != r_len) begin
                        o_re        = 1'b1;
                        n_pend      = 1'b1;
                        n_pend_last = (r_rd_cnt + POS_W'(1)) == r_len;
                        n_rd_cnt    = r_rd_cnt + POS_W'(1);
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_decl       <= '0;
            r_len        <= '0;
            r_rd_cnt     <= '0;
            r_pend       <= 1'b0;
            r_pend_last  <= 1'b0;
            r_start_char <= 8'd2;
            r_end_char   <= 8'd3;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_decl      <= n_decl;
            r_len       <= n_len;
            r_rd_cnt    <= n_rd_cnt;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_START_CHAR) begin
                    r_start_char <= i_cfg_data;
                end else if (i_cfg_index == CFG_END_CHAR) begin
                    r_end_char <= i_cfg_data;
                end
            end
        end
    end

endmodule

FILE: rtl/length_framed_byte_receiver_unit.sv
// Top level of the length framed byte receiver: parser, frame store and
// output register. Depends on lfbr_pkg, lfbr_store, lfbr_out and lfbr_ctrl.
//
// The receiver takes one byte per input word and assembles frames of the
// form start byte, 16-bit little-endian length, payload, end byte. Bytes
// outside a frame other than the start byte are dropped silently. A frame
// whose end byte arrives exactly after the declared length is replayed from
// the frame store as one output word per payload byte (tlast on the final
// one), or as a single empty-message word when the length is zero. An early
// end byte gives an invalid-size word, a wrong byte where the end byte
// belongs gives a terminator-missing word, and a payload that would not fit
// BUF_BYTES bytes (header and end byte included) gives an overflow word;
// each of these returns the receiver to waiting for a start byte. While
// parsing, one byte is accepted per cycle as long as the output register
// is empty or being emptied in that cycle. After a good frame the input is
// held off for the replay, which reads the store through its single read
// port with registered read data. The store needs no clearing after reset.
// The start and end byte values are written through the configuration port
// (index 0 and 1); the user must write them only while the receiver is
// idle, which the block itself does not enforce. They reset to 2 and 3.
module length_framed_byte_receiver_unit #(
    parameter int BUF_BYTES = lfbr_pkg::BUF_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: tdata[7:0] rx_byte.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // Master side: tdata[7:0] payload_byte, tdata[13:8] msg_length,
    // tdata[15:14] zero.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,
    // tuser[2:0] kind.
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import lfbr_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          slot_free;
    t_res_push     push;
    t_result       res;

    // Registers are always writable.
    assign o_cfg_ready = 1'b1;

    lfbr_ctrl #(
        .BUF_BYTES (BUF_BYTES),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .i_slot_free (slot_free),
        .o_push      (push)
    );

    lfbr_store #(
        .DEPTH (BUF_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lfbr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_slot_free (slot_free),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {2'b00, res.msg_length, res.payload_byte};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule
